// File: rtl/fet_pkg.sv
// Shared types and constants for the 2x2 Fisher exact test core.
`timescale 1ns / 1ps
package fet_pkg;

    localparam int MaxTotal = 1024;
    localparam int IdxW     = $clog2(MaxTotal + 1);
    localparam int LfW      = 33;
    localparam int ExpSteps = 25;
    localparam int ExpIdxW  = 5;
    localparam int QW       = 63;
    localparam int LogW     = 38;
    localparam int SumW     = 43;

    localparam logic [QW-1:0] OneQ62 = 63'h4000_0000_0000_0000;
    localparam logic [QW-1:0] ExpE0  =
        OneQ62 - (63'd1 << 42) + (63'd1 << 21) - 63'd1;

    localparam logic [1:0] OpTwo     = 2'd0;
    localparam logic [1:0] OpLess    = 2'd1;
    localparam logic [1:0] OpGreater = 2'd2;
    // unused code, treated as two-tailed
    localparam logic [1:0] OpSpare   = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [10:0] count_a;
        logic [10:0] count_b;
        logic [10:0] count_c;
        logic [10:0] count_d;
    } req_t;

    typedef struct packed {
        logic [32:0] p_value;
        logic        total_too_large;
    } rsp_t;

    typedef struct packed {
        logic            we;
        logic [IdxW-1:0] addr;
        logic [LfW-1:0]  data;
    } lf_wr_t;

endpackage

// File: rtl/fet_lf_ram.sv
// ln(n!) table memory: one write port, one registered read port.
`timescale 1ns / 1ps
module fet_lf_ram (
    input  logic                      clk,
    input  fet_pkg::lf_wr_t           wr,
    input  logic                      rd_en,
    input  logic [fet_pkg::IdxW-1:0]  rd_addr,
    output logic [fet_pkg::LfW-1:0]   rd_data
);

    logic [fet_pkg::LfW-1:0] mem [0:fet_pkg::MaxTotal];

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/fet_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module fet_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [60:0] dividend,
    input  logic [21:0] divisor,
    output logic [60:0] quotient,
    output logic        done
);

    logic [5:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic [60:0] num_reg, num_next;
    logic [21:0] rem_reg, rem_next;
    logic [21:0] den_reg, den_next;
    logic [22:0] trial;
    logic        ge;

    always_comb
    begin
        trial     = {rem_reg, num_reg[60]};
        ge        = (trial >= {1'b0, den_reg});
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = 6'd61;
            num_next = dividend;
            rem_next = '0;
            den_next = divisor;
        end
        else if (cnt_reg != 6'd0)
        begin
            rem_next  = ge ? 22'(trial - {1'b0, den_reg}) : trial[21:0];
            num_next  = {num_reg[59:0], ge};
            cnt_next  = cnt_reg - 6'd1;
            done_next = (cnt_reg == 6'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quotient = num_reg;
    assign done     = done_reg;

endmodule

// File: rtl/fet_mul62.sv
// Q62 x Q62 multiply, rounded to Q62; half-word products, sum, result registered.
`timescale 1ns / 1ps
module fet_mul62 (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [fet_pkg::QW-1:0]  x,
    input  logic [fet_pkg::QW-1:0]  y,
    output logic [fet_pkg::QW-1:0]  res,
    output logic                    valid
);

    logic         v1_reg, v2_reg, v3_reg;
    logic [63:0]  ll_reg;
    logic [62:0]  lh_reg, hl_reg;
    logic [61:0]  hh_reg;
    logic [125:0] s_reg;
    logic [125:0] s_next;
    logic [63:0]  r_next;
    logic [fet_pkg::QW-1:0] res_reg;

    always_comb
    begin
        s_next = {hh_reg, 64'd0} + {31'd0, lh_reg, 32'd0} + {31'd0, hl_reg, 32'd0}
               + {62'd0, ll_reg};
        r_next = s_reg[125:62] + {63'd0, s_reg[61]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ll_reg  <= x[31:0] * y[31:0];
        lh_reg  <= x[31:0] * y[62:32];
        hl_reg  <= x[62:32] * y[31:0];
        hh_reg  <= x[62:32] * y[62:32];
        s_reg   <= s_next;
        res_reg <= r_next[fet_pkg::QW-1:0];
    end

    assign res   = res_reg;
    assign valid = v3_reg;

endmodule

// File: rtl/fet_init.sv
// Builds the ln(n!) table after reset from a fixed-point atanh series.
`timescale 1ns / 1ps
module fet_init (
    input  logic            clk,
    input  logic            rst_n,
    output fet_pkg::lf_wr_t wr,
    output logic            ready
);

    localparam logic [3:0] I_ZERO  = 4'd0;
    localparam logic [3:0] I_KST   = 4'd1;
    localparam logic [3:0] I_DIV0  = 4'd2;
    localparam logic [3:0] I_SER   = 4'd3;
    localparam logic [3:0] I_DIVJ  = 4'd4;
    localparam logic [3:0] I_DIVQ  = 4'd5;
    localparam logic [3:0] I_ACC   = 4'd6;
    localparam logic [3:0] I_WRITE = 4'd7;
    localparam logic [3:0] I_DONE  = 4'd8;

    logic [3:0]  state_reg, state_next;
    logic [fet_pkg::IdxW-1:0] k_reg, k_next;
    logic [21:0] qq_reg, qq_next;
    logic [60:0] t_reg, t_next;
    logic [7:0]  j_reg, j_next;
    logic [60:0] sum_reg, sum_next;
    logic [63:0] lnk_reg, lnk_next;
    logic [53:0] acc_reg, acc_next;
    logic [11:0] q_full;
    logic        div_start;
    logic [60:0] div_num;
    logic [21:0] div_den;
    logic [60:0] div_quot;
    logic        div_done;
    logic [63:0] lnk_rnd;
    logic [53:0] acc_rnd;

    fet_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .quotient (div_quot),
        .done     (div_done)
    );

    always_comb
    begin
        q_full     = {k_reg, 1'b0} - 12'd1;
        lnk_rnd    = lnk_reg + (64'd1 << 18);
        acc_rnd    = acc_reg + (54'd1 << 19);
        state_next = state_reg;
        k_next     = k_reg;
        qq_next    = qq_reg;
        t_next     = t_reg;
        j_next     = j_reg;
        sum_next   = sum_reg;
        lnk_next   = lnk_reg;
        acc_next   = acc_reg;
        div_start  = 1'b0;
        div_num    = t_reg;
        div_den    = {14'd0, j_reg};
        wr.we      = 1'b0;
        wr.addr    = k_reg;
        wr.data    = acc_rnd[52:20];
        case (state_reg)
            I_ZERO:
            begin
                wr.we      = 1'b1;
                wr.addr    = '0;
                wr.data    = '0;
                k_next     = fet_pkg::IdxW'(1);
                state_next = I_KST;
            end
            I_KST:
            begin
                if (k_reg == fet_pkg::IdxW'(1))
                begin
                    state_next = I_ACC;
                end
                else
                begin
                    qq_next    = q_full[10:0] * q_full[10:0];
                    div_start  = 1'b1;
                    div_num    = 61'd1 << 60;
                    div_den    = {11'd0, q_full[10:0]};
                    j_next     = 8'd1;
                    sum_next   = '0;
                    state_next = I_DIV0;
                end
            end
            I_DIV0:
            begin
                if (div_done)
                begin
                    t_next     = div_quot;
                    state_next = I_SER;
                end
            end
            I_SER:
            begin
                if (t_reg == '0)
                begin
                    lnk_next   = lnk_reg + {3'd0, sum_reg};
                    state_next = I_ACC;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = I_DIVJ;
                end
            end
            I_DIVJ:
            begin
                if (div_done)
                begin
                    sum_next   = sum_reg + div_quot;
                    div_start  = 1'b1;
                    div_den    = qq_reg;
                    state_next = I_DIVQ;
                end
            end
            I_DIVQ:
            begin
                if (div_done)
                begin
                    t_next     = div_quot;
                    j_next     = j_reg + 8'd2;
                    state_next = I_SER;
                end
            end
            I_ACC:
            begin
                acc_next   = acc_reg + {9'd0, lnk_rnd[63:19]};
                state_next = I_WRITE;
            end
            I_WRITE:
            begin
                wr.we = 1'b1;
                if (k_reg == fet_pkg::IdxW'(fet_pkg::MaxTotal))
                begin
                    state_next = I_DONE;
                end
                else
                begin
                    k_next     = k_reg + fet_pkg::IdxW'(1);
                    state_next = I_KST;
                end
            end
            I_DONE:
            begin
                state_next = I_DONE;
            end
            default:
            begin
                state_next = I_ZERO;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= I_ZERO;
            k_reg     <= '0;
            lnk_reg   <= '0;
            acc_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            lnk_reg   <= lnk_next;
            acc_reg   <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qq_reg  <= qq_next;
        t_reg   <= t_next;
        j_reg   <= j_next;
        sum_reg <= sum_next;
    end

    assign ready = (state_reg == I_DONE);

endmodule

// File: rtl/fisher_exact_test_2x2_core.sv
// Top level: 2x2 Fisher exact test sweep over an ln(n!) memory.
`timescale 1ns / 1ps
// After reset the core builds its ln(n!) table and exp factor table; busy
// stays high for this pass (two bit-serial divisions per series step, three
// or four steps for most entries and more for the first few).
// A command is taken when start is high and busy is low. The core sweeps
// the tables with the observed margins one at a time (for a one-sided test
// only those on the tested side): each costs four reads on the single read
// port, one compare and, for a negative log term in range, 25 exp bit steps
// plus a closing step and a multiply by an exp factor for each set bit.
// The result comes with done, high for one cycle; the receiver cannot stall
// it. tie tolerance may be written at any time the core is idle.
module fisher_exact_test_2x2_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  fet_pkg::req_t request,
    input  logic          cfg_we,
    input  logic [15:0]   cfg_wdata,
    output logic          done,
    output fet_pkg::rsp_t result
);

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_ETAB  = 4'd1;
    localparam logic [3:0] S_ETABW = 4'd2;
    localparam logic [3:0] S_IDLE  = 4'd3;
    localparam logic [3:0] S_BASE  = 4'd4;
    localparam logic [3:0] S_OBS   = 4'd5;
    localparam logic [3:0] S_TERM  = 4'd6;
    localparam logic [3:0] S_EVAL  = 4'd7;
    localparam logic [3:0] S_EXP   = 4'd8;
    localparam logic [3:0] S_MULW  = 4'd9;
    localparam logic [3:0] S_NEXT  = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;

    localparam int IW = fet_pkg::IdxW;
    localparam int LW = fet_pkg::LogW;

    logic [3:0]     state_reg, state_next;
    logic           two_reg, two_next;
    logic           big_reg, big_next;
    logic [IW-1:0]  a_reg, a_next, b_reg, b_next, c_reg, c_next, d_reg, d_next;
    logic [IW-1:0]  n1_reg, n1_next, n2_reg, n2_next, m1_reg, m1_next;
    logic [IW-1:0]  m2_reg, m2_next, tot_reg, tot_next;
    logic [IW-1:0]  x_reg, x_next, hi_reg, hi_next;
    logic [2:0]     g_idx_reg, g_idx_next;
    logic           rd_pend_reg, rd_pend_next, rd_neg_reg, rd_neg_next;
    logic signed [LW-1:0] gsum_reg, gsum_next, base_reg, base_next;
    logic signed [LW-1:0] obs_reg, obs_next, lg_reg, lg_next;
    logic [fet_pkg::ExpSteps-1:0] xexp_reg, xexp_next;
    logic [fet_pkg::QW-1:0] p_reg, p_next;
    logic [fet_pkg::ExpIdxW-1:0] k_reg, k_next, ei_reg, ei_next;
    logic [fet_pkg::SumW-1:0] acc_reg, acc_next;
    logic [15:0]    tol_reg;
    logic           done_reg, done_next;
    fet_pkg::rsp_t  rsp_reg, rsp_next;
    logic [fet_pkg::QW-1:0] etab_reg [0:fet_pkg::ExpSteps-1];
    logic           etab_we;
    logic [fet_pkg::ExpIdxW-1:0] etab_widx;
    logic [fet_pkg::QW-1:0] etab_wdata;

    fet_pkg::lf_wr_t lf_wr;
    logic           init_ready;
    logic           rd_en;
    logic [IW-1:0]  rd_addr;
    logic [fet_pkg::LfW-1:0] rd_data;
    logic           mul_start, mul_valid;
    logic [fet_pkg::QW-1:0] mul_x, mul_y, mul_res;
    logic [fet_pkg::ExpIdxW-1:0] e_idx;

    logic [12:0]    tot_w;
    logic [11:0]    n1_w, n2_w, m1_w, m2_w, hi_w;
    logic [IW-1:0]  lo_w;
    logic [IW-1:0]  cb_w, cc_w, cd_w;
    logic [2:0]     g_lim;
    logic           g_neg;
    logic           g_done;
    logic signed [LW-1:0] thr_w, neg_lg;
    logic [63:0]    term_w;

    fet_init u_init (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (lf_wr),
        .ready (init_ready)
    );

    fet_lf_ram u_ram (
        .clk     (clk),
        .wr      (lf_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    fet_mul62 u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .x     (mul_x),
        .y     (mul_y),
        .res   (mul_res),
        .valid (mul_valid)
    );

    always_comb
    begin
        e_idx = (state_reg == S_ETAB) ? ei_reg - fet_pkg::ExpIdxW'(1) : k_reg;
        mul_x = (state_reg == S_ETAB) ? etab_reg[e_idx] : p_reg;
        mul_y = etab_reg[e_idx];
    end

    always_comb
    begin
        tot_w = {2'd0, request.count_a} + {2'd0, request.count_b}
              + {2'd0, request.count_c} + {2'd0, request.count_d};
        n1_w  = {1'b0, request.count_a} + {1'b0, request.count_b};
        n2_w  = {1'b0, request.count_c} + {1'b0, request.count_d};
        m1_w  = {1'b0, request.count_a} + {1'b0, request.count_c};
        m2_w  = {1'b0, request.count_b} + {1'b0, request.count_d};
        lo_w  = (request.count_a > request.count_d) ?
                IW'(request.count_a - request.count_d) : '0;
        hi_w  = (n1_w < m1_w) ? n1_w : m1_w;
        if (request.operation == fet_pkg::OpLess)
        begin
            hi_w = {1'b0, request.count_a};
        end
        if (request.operation == fet_pkg::OpGreater)
        begin
            lo_w = IW'(request.count_a);
        end
        cb_w  = n1_reg - x_reg;
        cc_w  = m1_reg - x_reg;
        cd_w  = n2_reg - cc_w;
        thr_w = obs_reg + LW'(signed'({1'b0, tol_reg}));
        neg_lg = -lg_reg;
        term_w = {1'b0, p_reg} + (64'd1 << 29);
    end

    // Read address sequencer for the log-factorial sums.
    always_comb
    begin
        g_lim   = (state_reg == S_BASE) ? 3'd5 : 3'd4;
        g_neg   = 1'b1;
        rd_addr = x_reg;
        case (state_reg)
            S_BASE:
            begin
                g_neg = (g_idx_reg == 3'd4);
                case (g_idx_reg)
                    3'd0:    rd_addr = n1_reg;
                    3'd1:    rd_addr = n2_reg;
                    3'd2:    rd_addr = m1_reg;
                    3'd3:    rd_addr = m2_reg;
                    default: rd_addr = tot_reg;
                endcase
            end
            S_OBS:
            begin
                case (g_idx_reg)
                    3'd0:    rd_addr = a_reg;
                    3'd1:    rd_addr = b_reg;
                    3'd2:    rd_addr = c_reg;
                    default: rd_addr = d_reg;
                endcase
            end
            default:
            begin
                case (g_idx_reg)
                    3'd0:    rd_addr = x_reg;
                    3'd1:    rd_addr = cb_w;
                    3'd2:    rd_addr = cc_w;
                    default: rd_addr = cd_w;
                endcase
            end
        endcase
        rd_en  = ((state_reg == S_BASE) || (state_reg == S_OBS) || (state_reg == S_TERM))
                 && (g_idx_reg < g_lim);
        g_done = (g_idx_reg == g_lim) && !rd_pend_reg;
    end

    always_comb
    begin
        state_next   = state_reg;
        two_next     = two_reg;
        big_next     = big_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        c_next       = c_reg;
        d_next       = d_reg;
        n1_next      = n1_reg;
        n2_next      = n2_reg;
        m1_next      = m1_reg;
        m2_next      = m2_reg;
        tot_next     = tot_reg;
        x_next       = x_reg;
        hi_next      = hi_reg;
        g_idx_next   = g_idx_reg;
        rd_pend_next = 1'b0;
        rd_neg_next  = rd_neg_reg;
        gsum_next    = gsum_reg;
        base_next    = base_reg;
        obs_next     = obs_reg;
        lg_next      = lg_reg;
        xexp_next    = xexp_reg;
        p_next       = p_reg;
        k_next       = k_reg;
        ei_next      = ei_reg;
        acc_next     = acc_reg;
        done_next    = 1'b0;
        rsp_next     = rsp_reg;
        mul_start    = 1'b0;
        etab_we      = 1'b0;
        etab_widx    = ei_reg;
        etab_wdata   = mul_res;

        if (rd_en)
        begin
            g_idx_next   = g_idx_reg + 3'd1;
            rd_pend_next = 1'b1;
            rd_neg_next  = g_neg;
        end
        if (rd_pend_reg)
        begin
            if (rd_neg_reg)
            begin
                gsum_next = gsum_reg - LW'(signed'({1'b0, rd_data}));
            end
            else
            begin
                gsum_next = gsum_reg + LW'(signed'({1'b0, rd_data}));
            end
        end

        case (state_reg)
            S_INIT:
            begin
                if (init_ready)
                begin
                    etab_we    = 1'b1;
                    etab_widx  = '0;
                    etab_wdata = fet_pkg::ExpE0;
                    ei_next    = fet_pkg::ExpIdxW'(1);
                    state_next = S_ETAB;
                end
            end
            S_ETAB:
            begin
                mul_start  = 1'b1;
                state_next = S_ETABW;
            end
            S_ETABW:
            begin
                if (mul_valid)
                begin
                    etab_we = 1'b1;
                    if (ei_reg == fet_pkg::ExpIdxW'(fet_pkg::ExpSteps - 1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ei_next    = ei_reg + fet_pkg::ExpIdxW'(1);
                        state_next = S_ETAB;
                    end
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    two_next   = !((request.operation == fet_pkg::OpLess) ||
                                   (request.operation == fet_pkg::OpGreater));
                    big_next   = (tot_w > 13'(fet_pkg::MaxTotal));
                    a_next     = IW'(request.count_a);
                    b_next     = IW'(request.count_b);
                    c_next     = IW'(request.count_c);
                    d_next     = IW'(request.count_d);
                    n1_next    = n1_w[IW-1:0];
                    n2_next    = n2_w[IW-1:0];
                    m1_next    = m1_w[IW-1:0];
                    m2_next    = m2_w[IW-1:0];
                    tot_next   = tot_w[IW-1:0];
                    x_next     = lo_w;
                    hi_next    = hi_w[IW-1:0];
                    g_idx_next = '0;
                    gsum_next  = '0;
                    acc_next   = '0;
                    state_next = (tot_w > 13'(fet_pkg::MaxTotal)) ? S_FIN : S_BASE;
                end
            end
            S_BASE:
            begin
                if (g_done)
                begin
                    base_next  = gsum_reg;
                    g_idx_next = '0;
                    state_next = S_OBS;
                end
            end
            S_OBS:
            begin
                if (g_done)
                begin
                    obs_next   = gsum_reg;
                    gsum_next  = base_reg;
                    g_idx_next = '0;
                    state_next = S_TERM;
                end
            end
            S_TERM:
            begin
                if (g_done)
                begin
                    lg_next    = gsum_reg;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = S_NEXT;
                if (two_reg && (lg_reg > thr_w))
                begin
                    state_next = S_NEXT;
                end
                else if (!lg_reg[LW-1])
                begin
                    acc_next = acc_reg + (fet_pkg::SumW'(1) << 32);
                end
                else if (neg_lg[LW-1:fet_pkg::ExpSteps] == '0)
                begin
                    xexp_next  = neg_lg[fet_pkg::ExpSteps-1:0];
                    p_next     = fet_pkg::OneQ62;
                    k_next     = '0;
                    state_next = S_EXP;
                end
            end
            S_EXP:
            begin
                if (k_reg == fet_pkg::ExpIdxW'(fet_pkg::ExpSteps))
                begin
                    acc_next   = acc_reg + fet_pkg::SumW'(term_w[63:30]);
                    state_next = S_NEXT;
                end
                else if (xexp_reg[k_reg])
                begin
                    mul_start  = 1'b1;
                    state_next = S_MULW;
                end
                else
                begin
                    k_next = k_reg + fet_pkg::ExpIdxW'(1);
                end
            end
            S_MULW:
            begin
                if (mul_valid)
                begin
                    p_next     = mul_res;
                    k_next     = k_reg + fet_pkg::ExpIdxW'(1);
                    state_next = S_EXP;
                end
            end
            S_NEXT:
            begin
                if (x_reg == hi_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    x_next     = x_reg + IW'(1);
                    gsum_next  = base_reg;
                    g_idx_next = '0;
                    state_next = S_TERM;
                end
            end
            S_FIN:
            begin
                done_next                = 1'b1;
                rsp_next.total_too_large = big_reg;
                if (big_reg)
                begin
                    rsp_next.p_value = '0;
                end
                else if (acc_reg > (fet_pkg::SumW'(1) << 32))
                begin
                    rsp_next.p_value = 33'h1_0000_0000;
                end
                else
                begin
                    rsp_next.p_value = acc_reg[32:0];
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_INIT;
            g_idx_reg   <= '0;
            rd_pend_reg <= 1'b0;
            k_reg       <= '0;
            ei_reg      <= '0;
            tol_reg     <= 16'd1;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            g_idx_reg   <= g_idx_next;
            rd_pend_reg <= rd_pend_next;
            k_reg       <= k_next;
            ei_reg      <= ei_next;
            done_reg    <= done_next;
            if (cfg_we)
            begin
                tol_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        two_reg    <= two_next;
        big_reg    <= big_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        d_reg      <= d_next;
        n1_reg     <= n1_next;
        n2_reg     <= n2_next;
        m1_reg     <= m1_next;
        m2_reg     <= m2_next;
        tot_reg    <= tot_next;
        x_reg      <= x_next;
        hi_reg     <= hi_next;
        rd_neg_reg <= rd_neg_next;
        gsum_reg   <= gsum_next;
        base_reg   <= base_next;
        obs_reg    <= obs_next;
        lg_reg     <= lg_next;
        xexp_reg   <= xexp_next;
        p_reg      <= p_next;
        acc_reg    <= acc_next;
        rsp_reg    <= rsp_next;
        if (etab_we)
        begin
            etab_reg[etab_widx] <= etab_wdata;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = rsp_reg;

endmodule

// File: rtl/fet_chk.sv
// Port-level checks for the Fisher exact test core, bound to the top level.
`timescale 1ns / 1ps
module fet_chk (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input fet_pkg::rsp_t result
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("result beat while busy or without prior work");

    a_p_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.p_value <= 33'h1_0000_0000))
        else $error("p_value above one");

    a_big_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.total_too_large) |-> (result.p_value == 33'd0))
        else $error("p_value nonzero on oversized table");

endmodule

bind fisher_exact_test_2x2_core fet_chk u_fet_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

// File: tb/fisher_exact_test_2x2_core_tb.sv
// Self-checking testbench for the 2x2 Fisher exact test core.
`timescale 1ns / 1ps
module fisher_exact_test_2x2_core_tb;

    localparam int WatchLimit = 3_000_000;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  start = 1'b0;
    logic  busy;
    fet_pkg::req_t request = '0;
    logic  cfg_we = 1'b0;
    logic  [15:0] cfg_wdata = '0;
    logic  done;
    fet_pkg::rsp_t result;

    longint unsigned lnfact[fet_pkg::MaxTotal + 1];
    longint unsigned exp_factor[fet_pkg::ExpSteps];
    longint unsigned tol_model = 1;
    fet_pkg::rsp_t pending_results[$];
    bit    failed = 1'b0;
    int    idle_cycles = 0;

    fisher_exact_test_2x2_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .result    (result)
    );

    always #5 clk = ~clk;

    // rounded Q62 product
    function automatic longint unsigned mul_q62(longint unsigned x, longint unsigned y);
        logic [127:0] prod;
        begin
            prod = 128'(x) * 128'(y) + (128'd1 << 61);
            return prod[125:62];
        end
    endfunction

    function automatic longint unsigned ln_ratio(longint unsigned k);
        longint unsigned q, qq, t, s, j;
        begin
            q = 2 * k - 1;
            qq = q * q;
            t = (64'd1 << 60) / q;
            s = 0;
            j = 1;
            while (t != 0)
            begin
                s += t / j;
                t /= qq;
                j += 2;
            end
            return s;
        end
    endfunction

    task automatic build_tables();
        longint unsigned ln_k, acc;
        begin
            ln_k = 0;
            acc = 0;
            lnfact[0] = 0;
            for (int k = 1; k <= fet_pkg::MaxTotal; k++)
            begin
                if (k >= 2)
                    ln_k += ln_ratio(k);
                acc += (ln_k + (64'd1 << 18)) >> 19;
                lnfact[k] = (acc + (64'd1 << 19)) >> 20;
            end
            exp_factor[0] = 64'(fet_pkg::ExpE0);
            for (int i = 1; i < fet_pkg::ExpSteps; i++)
                exp_factor[i] = mul_q62(exp_factor[i-1], exp_factor[i-1]);
        end
    endtask

    function automatic longint log_hyper(longint unsigned a, longint unsigned b,
                                         longint unsigned c, longint unsigned d);
        longint num, den;
        begin
            num = longint'(lnfact[a+b] + lnfact[c+d] + lnfact[a+c] + lnfact[b+d]);
            den = longint'(lnfact[a] + lnfact[b] + lnfact[c] + lnfact[d]
                           + lnfact[a+b+c+d]);
            return num - den;
        end
    endfunction

    function automatic longint unsigned exp_q32(longint lg);
        longint unsigned x, p;
        begin
            if (lg >= 0)
                return 64'd1 << 32;
            x = longint'(-lg);
            if (x >= (64'd1 << fet_pkg::ExpSteps))
                return 0;
            p = 64'(fet_pkg::OneQ62);
            for (int k = 0; k < fet_pkg::ExpSteps; k++)
                if (x[k])
                    p = mul_q62(p, exp_factor[k]);
            return (p + (64'd1 << 29)) >> 30;
        end
    endfunction

    function automatic fet_pkg::rsp_t predict_pvalue(fet_pkg::req_t r);
        fet_pkg::rsp_t res;
        longint unsigned a, b, c, d, n1, m1, n2, lo, hi, sum, cc;
        longint obs, lg;
        begin
            a = r.count_a; b = r.count_b; c = r.count_c; d = r.count_d;
            res = '0;
            if (a + b + c + d > fet_pkg::MaxTotal)
            begin
                res.total_too_large = 1'b1;
                return res;
            end
            n1 = a + b; m1 = a + c; n2 = c + d;
            lo = (a > d) ? a - d : 0;
            hi = (n1 < m1) ? n1 : m1;
            obs = log_hyper(a, b, c, d);
            sum = 0;
            for (longint unsigned x = lo; x <= hi; x++)
            begin
                cc = m1 - x;
                if (r.operation == fet_pkg::OpLess && x > a) continue;
                if (r.operation == fet_pkg::OpGreater && x < a) continue;
                lg = log_hyper(x, n1 - x, cc, n2 - cc);
                if ((r.operation == fet_pkg::OpTwo || r.operation == fet_pkg::OpSpare)
                    && lg > obs + longint'(tol_model)) continue;
                sum += exp_q32(lg);
            end
            if (sum > (64'd1 << 32))
                sum = 64'd1 << 32;
            res.p_value = sum[32:0];
            return res;
        end
    endfunction

    // result checker and watchdog
    always @(posedge clk)
    begin
        fet_pkg::rsp_t exp_rsp;
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchLimit)
        begin
            $display("fisher_exact_test_2x2_core_tb failed");
            $finish;
        end
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result beat");
                failed = 1'b1;
            end
            else
            begin
                exp_rsp = pending_results.pop_front();
                if (result.p_value !== exp_rsp.p_value)
                begin
                    $error("p_value: expected %0d, got %0d", exp_rsp.p_value,
                           result.p_value);
                    failed = 1'b1;
                end
                if (result.total_too_large !== exp_rsp.total_too_large)
                begin
                    $error("total_too_large: expected %0b, got %0b",
                           exp_rsp.total_too_large, result.total_too_large);
                    failed = 1'b1;
                end
            end
        end
    end

    task automatic send_table(logic [1:0] op, int a, int b, int c, int d);
        fet_pkg::req_t r;
        int gap;
        begin
            r.operation = op;
            r.count_a = a[10:0]; r.count_b = b[10:0];
            r.count_c = c[10:0]; r.count_d = d[10:0];
            gap = $urandom_range(0, 99);
            gap = (gap < 70) ? 0 : (gap < 95) ? $urandom_range(1, 3)
                                              : $urandom_range(20, 60);
            if (gap > 0)
            begin
                @(negedge clk);
                start = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            start = 1'b1;
            request = r;
            while (busy) @(negedge clk);
            @(posedge clk);
            pending_results.push_back(predict_pvalue(r));
        end
    endtask

    task automatic write_tolerance(int unsigned value);
        begin
            @(negedge clk);
            start = 1'b0;
            while (pending_results.size() != 0 || busy) @(negedge clk);
            cfg_we = 1'b1;
            cfg_wdata = value[15:0];
            @(negedge clk);
            cfg_we = 1'b0;
            tol_model = value & 16'hffff;
        end
    endtask

    task automatic random_table();
        int sel, tot;
        logic [1:0] op;
        begin
            sel = $urandom_range(0, 99);
            op = $urandom_range(0, 99) < 5 ? fet_pkg::OpSpare : 2'($urandom_range(0, 2));
            if (sel < 75)
                send_table(op, $urandom_range(0, 6), $urandom_range(0, 6),
                           $urandom_range(0, 6), $urandom_range(0, 6));
            else if (sel < 90)
                send_table(op, $urandom_range(0, 15), $urandom_range(0, 15),
                           $urandom_range(0, 15), $urandom_range(0, 15));
            else if (sel < 93)
            begin
                // large valid total, lopsided so the sweep stays short
                tot = $urandom_range(200, 1024);
                send_table(op, $urandom_range(0, 8), $urandom_range(0, 8),
                           $urandom_range(0, 8), tot - 24);
            end
            else
                send_table(op, $urandom_range(0, 2047), $urandom_range(0, 2047),
                           $urandom_range(0, 2047), $urandom_range(0, 2047));
        end
    endtask

    task automatic test_directed();
        begin
            for (int op = 0; op < 4; op++)
                send_table(op[1:0], 0, 0, 0, 0);
            send_table(fet_pkg::OpTwo, 1024, 0, 0, 0);
            send_table(fet_pkg::OpLess, 0, 1024, 0, 0);
            send_table(fet_pkg::OpGreater, 0, 0, 1024, 0);
            send_table(fet_pkg::OpTwo, 0, 0, 0, 1024);
            send_table(fet_pkg::OpTwo, 1024, 1, 0, 0);
            send_table(fet_pkg::OpGreater, 2047, 2047, 2047, 2047);
            send_table(fet_pkg::OpTwo, 1, 9, 11, 3);
            send_table(fet_pkg::OpLess, 1, 9, 11, 3);
            send_table(fet_pkg::OpGreater, 1, 9, 11, 3);
            send_table(fet_pkg::OpSpare, 1, 9, 11, 3);
            send_table(fet_pkg::OpTwo, 5, 5, 5, 5);
            send_table(fet_pkg::OpTwo, 3, 0, 0, 3);
            send_table(fet_pkg::OpGreater, 12, 0, 0, 12);
            send_table(fet_pkg::OpTwo, 100, 300, 300, 324);
            send_table(fet_pkg::OpLess, 256, 256, 256, 256);
        end
    endtask

    task automatic test_tolerance_extremes();
        begin
            write_tolerance(0);
            send_table(fet_pkg::OpTwo, 5, 5, 5, 5);
            send_table(fet_pkg::OpTwo, 2, 4, 4, 2);
            repeat (120) random_table();
            write_tolerance(16'hffff);
            send_table(fet_pkg::OpTwo, 5, 5, 5, 5);
            send_table(fet_pkg::OpTwo, 7, 1, 1, 7);
            repeat (120) random_table();
        end
    endtask

    task automatic test_random();
        begin
            for (int phase = 0; phase < 4; phase++)
            begin
                write_tolerance($urandom_range(0, 65535));
                repeat (80) random_table();
            end
            write_tolerance(1);
            repeat (20) random_table();
        end
    endtask

    initial
    begin
        build_tables();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_tolerance_extremes();
        test_random();
        @(negedge clk);
        start = 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (!failed)
            $display("fisher_exact_test_2x2_core_tb passed");
        else
            $display("fisher_exact_test_2x2_core_tb failed");
        $finish;
    end

endmodule
